// ----- rtl/pipt_pkg.sv -----
// ----------------------------------------------------------------------------
// pipt_pkg
// Shared types and constants for the point-in-polygon test unit.
// ----------------------------------------------------------------------------
package pipt_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SUM_W   = PROD_W + 1;

    typedef logic [1:0] t_req;
    typedef logic [1:0] t_loc;

    localparam t_req REQ_START  = 2'd0;
    localparam t_req REQ_APPEND = 2'd1;
    localparam t_req REQ_QUERY  = 2'd2;

    localparam t_loc LOC_OUTSIDE  = 2'd0;
    localparam t_loc LOC_BOUNDARY = 2'd1;
    localparam t_loc LOC_INSIDE   = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic wr_en;    // store the incoming vertex
        logic wr_new;   // vertex starts a new polygon
        logic q_start;  // latch query point, clear accumulators
        logic rd_en;    // read one vertex for the edge walk
        logic rd_edge;  // this read closes an edge with the previous one
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic busy;     // edge pipeline still holds work
        t_loc location; // current answer
    } t_dp_sts;

endpackage

// ----- rtl/pipt_datapath.sv -----
// ----------------------------------------------------------------------------
// pipt_datapath
// Vertex store, vertex count and the edge pipeline: read, difference,
// products, then cross/dot test and parity accumulation.
// ----------------------------------------------------------------------------
module pipt_datapath
    import pipt_pkg::*;
#(
    parameter int MAX_VERTICES = 128,
    parameter int AW = $clog2(MAX_VERTICES),
    parameter int CW = $clog2(MAX_VERTICES + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic [AW-1:0]             i_rd_addr,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    output logic [CW-1:0]             o_count,
    output t_dp_sts                   o_sts
);

    logic [2*COORD_W-1:0] r_mem [MAX_VERTICES];
    logic [CW-1:0]        r_count;

    logic [2*COORD_W-1:0] r_rd_data;
    logic                 r_rd_vld;
    logic                 r_rd_edge;

    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;

    logic signed [DIFF_W-1:0] r_ax, r_ay, r_bx, r_by;
    logic                     r_d_vld;

    logic signed [PROD_W-1:0] r_p_ab, r_p_ba, r_p_xx, r_p_yy;
    logic                     r_up, r_dn, r_m_vld;

    logic r_bnd, r_par;

    logic signed [COORD_W-1:0] w_vx, w_vy;
    logic signed [DIFF_W-1:0]  n_dx, n_dy;
    logic signed [SUM_W-1:0]   w_cr, w_dt;
    logic                      w_bnd, w_tgl;

    // vertex store and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.wr_en) begin
            if (i_cmd.wr_new) begin
                r_count <= CW'(1);
            end else if (r_count < CW'(MAX_VERTICES)) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            if (i_cmd.wr_new) begin
                r_mem[0] <= {i_coord_x, i_coord_y};
            end else if (r_count < CW'(MAX_VERTICES)) begin
                r_mem[r_count[AW-1:0]] <= {i_coord_x, i_coord_y};
            end
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign w_vx = r_rd_data[2*COORD_W-1:COORD_W];
    assign w_vy = r_rd_data[COORD_W-1:0];

    always_comb begin
        n_dx = {w_vx[COORD_W-1], w_vx} - {r_px[COORD_W-1], r_px};
        n_dy = {w_vy[COORD_W-1], w_vy} - {r_py[COORD_W-1], r_py};
    end

    // cross of a and b, dot of a and b
    assign w_cr = {r_p_ab[PROD_W-1], r_p_ab} - {r_p_ba[PROD_W-1], r_p_ba};
    assign w_dt = {r_p_xx[PROD_W-1], r_p_xx} + {r_p_yy[PROD_W-1], r_p_yy};
    assign w_bnd = (w_cr == '0) && (w_dt <= 0);
    // upward edge needs cross > 0, downward edge the mirrored test
    assign w_tgl = (r_up && (w_cr > 0)) || (r_dn && (w_cr < 0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_d_vld  <= 1'b0;
            r_m_vld  <= 1'b0;
            r_bnd    <= 1'b0;
            r_par    <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            r_d_vld  <= r_rd_vld && r_rd_edge;
            r_m_vld  <= r_d_vld;
            if (i_cmd.q_start) begin
                r_bnd <= 1'b0;
                r_par <= 1'b0;
            end else if (r_m_vld) begin
                r_bnd <= r_bnd | w_bnd;
                r_par <= r_par ^ w_tgl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_edge <= i_cmd.rd_edge;
        end
        if (i_cmd.q_start) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
        if (r_rd_vld) begin
            r_ax <= r_bx;
            r_ay <= r_by;
            r_bx <= n_dx;
            r_by <= n_dy;
        end
        if (r_d_vld) begin
            r_p_ab <= r_ax * r_by;
            r_p_ba <= r_ay * r_bx;
            r_p_xx <= r_ax * r_bx;
            r_p_yy <= r_ay * r_by;
            r_up   <= (r_ay <= 0) && (r_by > 0);
            r_dn   <= (r_by <= 0) && (r_ay > 0);
        end
    end

    assign o_count       = r_count;
    assign o_sts.busy    = r_rd_vld | r_d_vld | r_m_vld;
    assign o_sts.location = r_bnd ? LOC_BOUNDARY : (r_par ? LOC_INSIDE : LOC_OUTSIDE);

endmodule

// ----- rtl/pipt_ctrl.sv -----
// ----------------------------------------------------------------------------
// pipt_ctrl
// Request decoder and edge-walk sequencer; holds the result word register.
// ----------------------------------------------------------------------------
module pipt_ctrl
    import pipt_pkg::*;
#(
    parameter int MAX_VERTICES = 128,
    parameter int AW = $clog2(MAX_VERTICES),
    parameter int CW = $clog2(MAX_VERTICES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  t_req          i_req,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output t_loc          o_location,
    input  logic [CW-1:0] i_count,
    input  t_dp_sts       i_sts,
    output t_dp_cmd       o_cmd,
    output logic [AW-1:0] o_rd_addr
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_k, n_k;
    logic          r_out_vld, n_out_vld;
    t_loc          r_out_loc, n_out_loc;
    logic          w_acc;
    logic          w_last;

    assign w_acc  = i_s_tvalid && (r_state == ST_IDLE);
    assign w_last = (r_k == i_count);

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_out_vld = r_out_vld;
        n_out_loc = r_out_loc;
        o_cmd     = '0;
        // the closing edge reads vertex 0 again
        o_rd_addr = w_last ? '0 : r_k[AW-1:0];

        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    case (i_req)
                        REQ_START: begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_new = 1'b1;
                        end
                        REQ_APPEND: begin
                            o_cmd.wr_en = 1'b1;
                        end
                        REQ_QUERY: begin
                            o_cmd.q_start = 1'b1;
                            n_k           = '0;
                            n_state       = (i_count == '0) ? ST_DRAIN : ST_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_edge = (r_k != '0);
                if (w_last) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            ST_DRAIN: begin
                if (!i_sts.busy && (!r_out_vld || i_m_tready)) begin
                    n_out_vld = 1'b1;
                    n_out_loc = i_sts.location;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_k       <= '0;
            r_out_vld <= 1'b0;
            r_out_loc <= LOC_OUTSIDE;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_out_vld <= n_out_vld;
            r_out_loc <= n_out_loc;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_location = r_out_loc;

endmodule

// ----- rtl/point_in_polygon_test_unit.sv -----
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit
// Crossing-number point-in-polygon test with boundary detection.
// ----------------------------------------------------------------------------
// Input stream words carry a request in tuser: start a polygon with this
// vertex, append a vertex, or query a point. Vertex words give no result
// and leave the input ready; appends beyond MAX_VERTICES are dropped.
// A query walks all n stored edges through one memory read port, one
// vertex per cycle (n+1 reads, vertex 0 read again to close the ring),
// then a three-stage difference/product/test pipeline drains. A query
// holds tready low until its answer is written to an output register,
// so no new word is taken while a query is in progress; the answer is
// 0 outside, 1 on boundary, 2 inside.
// The output register parts the two sides: new words are taken while an
// answer waits; a second query finishing while the receiver stalls holds
// in its drain state until the previous answer is taken.
// Reset clears the vertex count and the output valid; the vertex memory
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit
    import pipt_pkg::*;
#(
    parameter int MAX_VERTICES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] coord_x, [31:16] coord_y
    input  logic [1:0]  i_s_tuser,   // [1:0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // [1:0] location, [7:2] zero
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    t_dp_cmd       w_cmd;
    t_dp_sts       w_sts;
    logic [AW-1:0] w_rd_addr;
    logic [CW-1:0] w_count;
    t_loc          w_loc;

    pipt_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW),
        .CW           (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_req      (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_location (w_loc),
        .i_count    (w_count),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_rd_addr  (w_rd_addr)
    );

    pipt_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW),
        .CW           (CW)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_rd_addr (w_rd_addr),
        .i_coord_x (i_s_tdata[COORD_W-1:0]),
        .i_coord_y (i_s_tdata[2*COORD_W-1:COORD_W]),
        .o_count   (w_count),
        .o_sts     (w_sts)
    );

    assign o_m_tdata = {6'b0, w_loc};

endmodule

// ----- dv/point_in_polygon_test_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit_test
// Self-checking bench for the point-in-polygon test unit. Polygons are loaded
// word by word and probed with query points, and every answer is compared
// with a crossing-number predictor that keeps its own copy of the vertices.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit_test
    import pipt_pkg::*;
;

    localparam int   STORE_DEPTH  = 128;
    localparam int   RUN_LIMIT    = 1_000_000;
    localparam int   TARGET_ITEMS = 650;
    localparam t_req REQ_UNUSED   = 2'd3;

    class location_scoreboard;
        logic signed [15:0] vert_x [STORE_DEPTH];
        logic signed [15:0] vert_y [STORE_DEPTH];
        int unsigned        vert_count;
        t_loc               expected_locations [$];
        int unsigned        errors;

        function new();
            vert_count = 0;
            errors     = 0;
        endfunction

        function int pending();
            return expected_locations.size();
        endfunction

        // crossing number with exact integer edge tests
        function t_loc locate_point(logic signed [15:0] px, logic signed [15:0] py);
            longint ax, ay, bx, by, cr, dt, tmp;
            bit     odd;
            int     i, j;
            odd = 1'b0;
            for (i = 0; i < vert_count; i++) begin
                j  = (i + 1 == vert_count) ? 0 : i + 1;
                ax = longint'(vert_x[i]) - longint'(px);
                ay = longint'(vert_y[i]) - longint'(py);
                bx = longint'(vert_x[j]) - longint'(px);
                by = longint'(vert_y[j]) - longint'(py);
                cr = ax * by - ay * bx;
                dt = ax * bx + ay * by;
                if (cr == 0 && dt <= 0)
                    return LOC_BOUNDARY;
                if (ay > by) begin
                    tmp = ax; ax = bx; bx = tmp;
                    tmp = ay; ay = by; by = tmp;
                    cr  = -cr;
                end
                if (ay <= 0 && by > 0 && cr > 0)
                    odd = ~odd;
            end
            return odd ? LOC_INSIDE : LOC_OUTSIDE;
        endfunction

        function void note_request(t_req req, logic [15:0] x, logic [15:0] y);
            case (req)
                REQ_START: begin
                    vert_x[0]  = x;
                    vert_y[0]  = y;
                    vert_count = 1;
                end
                REQ_APPEND: begin
                    // full store drops the vertex
                    if (vert_count < STORE_DEPTH) begin
                        vert_x[vert_count] = x;
                        vert_y[vert_count] = y;
                        vert_count++;
                    end
                end
                REQ_QUERY: expected_locations = {expected_locations, locate_point(x, y)};
                default: ;
            endcase
        endfunction

        function void check_answer(logic [7:0] word);
            t_loc got;
            t_loc want;
            got = word[1:0];
            if (expected_locations.size() == 0) begin
                $error("location: unexpected answer, actual %0d", got);
                errors++;
                return;
            end
            want = expected_locations.pop_front();
            if (got !== want) begin
                $error("location mismatch: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    typedef struct packed {
        t_req        req;
        logic [15:0] x;
        logic [15:0] y;
    } t_request;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // [15:0] coord_x, [31:16] coord_y
    logic [1:0]  s_tuser  = '0;    // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [1:0] location, [7:2] zero

    location_scoreboard sb = new();

    t_request request_q [$];
    int       items_queued = 0;
    int       burst_left   = 0;
    int       gap_left     = 0;
    int       rx_mode      = 0;
    int       rx_mode_left = 0;
    int       rx_stall     = 0;
    int       cycle_count  = 0;

    point_in_polygon_test_unit #(
        .MAX_VERTICES(STORE_DEPTH)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // sender: bursts of words with random gaps between them
    always @(posedge clk) begin
        t_request w;
        if (rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata[15:0], s_tdata[31:16]);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    w = request_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= w.req;
                    s_tdata  <= {w.y, w.x};
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: always ready, coin flips, or long stalls
    always @(posedge clk) begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
            sb.check_answer(m_tdata);
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(20, 200);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            default: begin
                if (rx_stall > 0) begin
                    rx_stall--;
                    m_tready <= 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    rx_stall = $urandom_range(5, 30);
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    function automatic int clamp16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int coord_near(int c, int h);
        return clamp16(c + int'($urandom_range(0, 2 * h)) - h);
    endfunction

    function automatic void add_request(t_req req, int x, int y);
        t_request w;
        w.req = req;
        w.x   = 16'(x);
        w.y   = 16'(y);
        request_q = {request_q, w};
        if (req != REQ_UNUSED)
            items_queued++;
    endfunction

    task automatic wait_until_idle();
        while (request_q.size() != 0 || s_tvalid || sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic noise_words();
        repeat ($urandom_range(3, 10))
            add_request(t_req'($urandom_range(0, 3)), any_coord(), any_coord());
    endtask

    // one polygon with random content at a random scale, then queries on it
    task automatic polygon_words(bit fill_store);
        int cx, cy, half, n, nq, i, j, k, qx, qy;
        int xs [$];
        int ys [$];
        t_req first_req;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                half = $urandom_range(8, 40);
                cx   = any_coord();
                cy   = any_coord();
            end
            5, 6: begin
                half = $urandom_range(1000, 5000);
                cx   = any_coord();
                cy   = any_coord();
            end
            7: begin
                half = 32768;
                cx   = 0;
                cy   = 0;
            end
            8: begin
                // hug a corner so clamping hits the coordinate extremes
                half = 20;
                cx   = $urandom_range(0, 1) ? 32757 : -32758;
                cy   = $urandom_range(0, 1) ? 32757 : -32758;
            end
            default: begin
                half = 2;
                cx   = any_coord();
                cy   = any_coord();
            end
        endcase
        if (fill_store)
            n = STORE_DEPTH + 3;
        else if ($urandom_range(0, 49) == 0)
            n = $urandom_range(STORE_DEPTH - 8, STORE_DEPTH + 4);
        else if ($urandom_range(0, 9) == 0)
            n = $urandom_range(9, 40);
        else if ($urandom_range(0, 4) == 0)
            n = $urandom_range(1, 2);
        else
            n = $urandom_range(3, 8);
        first_req = ($urandom_range(0, 9) == 0) ? REQ_APPEND : REQ_START;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 29) == 0)
                add_request(REQ_UNUSED, any_coord(), any_coord());
            xs = {xs, coord_near(cx, half)};
            ys = {ys, coord_near(cy, half)};
            add_request((k == 0) ? first_req : REQ_APPEND, xs[k], ys[k]);
        end
        nq = $urandom_range(1, 8);
        repeat (nq) begin
            i = $urandom_range(0, xs.size() - 1);
            j = (i + 1) % xs.size();
            case ($urandom_range(0, 7))
                3: begin
                    qx = xs[i];
                    qy = ys[i];
                end
                4: begin
                    qx = (xs[i] + xs[j]) >>> 1;
                    qy = (ys[i] + ys[j]) >>> 1;
                end
                5: begin
                    // on the edge's line but past its end
                    qx = clamp16(2 * xs[i] - xs[j]);
                    qy = clamp16(2 * ys[i] - ys[j]);
                end
                6: begin
                    qx = any_coord();
                    qy = any_coord();
                end
                7: begin
                    qx = clamp16(xs[i] + int'($urandom_range(0, 2)) - 1);
                    qy = clamp16(ys[i] + int'($urandom_range(0, 2)) - 1);
                end
                default: begin
                    qx = coord_near(cx, half);
                    qy = coord_near(cy, half);
                end
            endcase
            add_request(REQ_QUERY, qx, qy);
        end
    endtask

    initial begin
        bit paused;
        bit fill_first;
        paused     = 1'b0;
        fill_first = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // empty store, then append with no polygon acting as a start
        add_request(REQ_QUERY,  0, 0);
        add_request(REQ_APPEND, 5, 5);
        add_request(REQ_QUERY,  5, 5);
        add_request(REQ_QUERY,  6, 5);
        // two vertices form a segment
        add_request(REQ_APPEND, 15, 5);
        add_request(REQ_QUERY,  10, 5);
        add_request(REQ_QUERY,  10, 6);
        add_request(REQ_UNUSED, -1, -1);
        // square at the coordinate extremes
        add_request(REQ_START,  -32768, -32768);
        add_request(REQ_APPEND,  32767, -32768);
        add_request(REQ_APPEND,  32767,  32767);
        add_request(REQ_APPEND, -32768,  32767);
        add_request(REQ_QUERY,       0,      0);
        add_request(REQ_QUERY,   32767,      0);
        add_request(REQ_QUERY,  -32768, -32768);
        add_request(REQ_QUERY,       1, -32768);
        // small triangle
        add_request(REQ_START,    0,   0);
        add_request(REQ_APPEND, 100,   0);
        add_request(REQ_APPEND,   0, 100);
        add_request(REQ_QUERY,   10,  10);
        add_request(REQ_QUERY,  100, 100);
        add_request(REQ_QUERY,   50,  50);
        add_request(REQ_QUERY, -32768, 32767);
        wait_until_idle();

        while (items_queued < TARGET_ITEMS) begin
            if (!paused && items_queued >= TARGET_ITEMS / 2) begin
                wait_until_idle();
                paused = 1'b1;
            end
            if ($urandom_range(0, 14) == 0) begin
                noise_words();
            end else begin
                polygon_words(fill_first);
                fill_first = 1'b0;
            end
        end

        wait_until_idle();
        repeat (20) @(posedge clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
